// ----- src/imsp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imsp_pkg: shared types and constants of the inline markup style parser
// Result records, the per-item result bundle, queue side-band structs,
// event/kind codes, markup characters and the header table.
// ----------------------------------------------------------------------------
package imsp_pkg;

	localparam int CHAR_W = 16;
	localparam int KIND_W = 2;
	localparam int EV_W   = 2;
	localparam int STY_W  = 4;

	// results one item can cause, and the widths to count and index them
	localparam int MAX_RES = 4;
	localparam int RIDX_W  = $clog2(MAX_RES);
	localparam int CNT_W   = $clog2(MAX_RES + 1);

	localparam int unsigned QUEUE_DEPTH = 4;

	// input kinds
	localparam logic [KIND_W-1:0] KIND_CHAR = 2'd0;
	localparam logic [KIND_W-1:0] KIND_EOL  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EOF  = 2'd2;

	// result events
	localparam logic [EV_W-1:0] EV_CHAR   = 2'd0;
	localparam logic [EV_W-1:0] EV_PARA   = 2'd1;
	localparam logic [EV_W-1:0] EV_CENTRE = 2'd2;
	localparam logic [EV_W-1:0] EV_ERROR  = 2'd3;

	// style bit positions
	localparam int ST_BOLD   = 0;
	localparam int ST_ITALIC = 1;
	localparam int ST_UNDER  = 2;
	localparam int ST_STRIKE = 3;

	// markup characters
	localparam logic [CHAR_W-1:0] CH_BSLASH = 16'h005C;
	localparam logic [CHAR_W-1:0] CH_GT     = 16'h003E;
	localparam logic [CHAR_W-1:0] CH_LT     = 16'h003C;
	localparam logic [CHAR_W-1:0] CH_STAR   = 16'h002A;
	localparam logic [CHAR_W-1:0] CH_UNDER  = 16'h005F;
	localparam logic [CHAR_W-1:0] CH_TILDE  = 16'h007E;

	localparam int HDR_LEN = 9;

	typedef struct packed {
		logic [EV_W-1:0]   ev;
		logic [CHAR_W-1:0] ch;
		logic [STY_W-1:0]  sty;
	} res_t;

	typedef struct packed {
		logic [CNT_W-1:0]        cnt;
		res_t [MAX_RES-1:0]      res;
	} bundle_t;

	typedef struct packed {
		logic    push;
		bundle_t data;
	} q_wr_t;

	typedef struct packed {
		logic    empty;
		bundle_t data;
	} q_rd_t;

	// "/*MTXT1*/" one unit per position
	function automatic logic [CHAR_W-1:0] hdr_unit(input logic [3:0] pos);
		logic [CHAR_W-1:0] u;
		case (pos)
			4'd0: u = 16'h002F;
			4'd1: u = 16'h002A;
			4'd2: u = 16'h004D;
			4'd3: u = 16'h0054;
			4'd4: u = 16'h0058;
			4'd5: u = 16'h0054;
			4'd6: u = 16'h0031;
			4'd7: u = 16'h002A;
			4'd8: u = 16'h002F;
			default: u = '0;
		endcase
		return u;
	endfunction

endpackage
`default_nettype wire

// ----- src/imsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imsp_if: valid/ready channels of the inline markup style parser
// Item channel (code unit + kind) and result channel (styled events).
// ----------------------------------------------------------------------------
interface imsp_item_if;
	import imsp_pkg::*;
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] code;
	logic [KIND_W-1:0] kind;

	modport source (output valid, code, kind, input ready);
	modport sink   (input valid, code, kind, output ready);
endinterface

interface imsp_res_if;
	import imsp_pkg::*;
	logic              valid;
	logic              ready;
	logic [EV_W-1:0]   event_res;
	logic [CHAR_W-1:0] char_out;
	logic              bold;
	logic              italic;
	logic              underline;
	logic              strike;
	logic              last;

	modport source (output valid, event_res, char_out, bold, italic, underline, strike, last,
		input ready);
	modport sink   (input valid, event_res, char_out, bold, italic, underline, strike, last,
		output ready);
endinterface
`default_nettype wire

// ----- src/imsp_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imsp_front: request intake and markup classification
// Holds the parse state, resolves the lookahead window combinationally and
// pushes the bundle of results caused by each request into the queue.
// ----------------------------------------------------------------------------
module imsp_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	imsp_item_if.sink           items,
	input  wire logic           q_full,
	output imsp_pkg::q_wr_t     q_wr
);
	import imsp_pkg::*;

	typedef enum logic [3:0] {
		PH_HEADER = 4'b0001,
		PH_SKIP   = 4'b0010,
		PH_BODY   = 4'b0100,
		PH_ERROR  = 4'b1000
	} phase_t;

	phase_t            phase_q, phase_d;
	logic [3:0]        hdr_pos_q, hdr_pos_d;
	logic              first_line_q, first_line_d;
	logic              line_zero_q, line_zero_d;
	logic              centred_q, centred_d;
	logic [1:0]        pend_cnt_q, pend_cnt_d;
	logic [STY_W-1:0]  style_q, style_d;
	logic [CHAR_W-1:0] pend_q [2];
	logic [CHAR_W-1:0] pend_d [2];

	logic              accept;
	bundle_t           bnd;
	logic              rs_char, rs_endl, rs_eol, rs_stop;
	logic [CHAR_W-1:0] win [3];
	logic [1:0]        rs_n;
	logic [1:0]        used;
	logic [CHAR_W-1:0] c;

	function automatic bundle_t put_res(input bundle_t b, input logic [EV_W-1:0] ev,
		input logic [CHAR_W-1:0] ch, input logic [STY_W-1:0] sty);
		bundle_t r;
		r = b;
		if (b.cnt < CNT_W'(MAX_RES)) begin
			r.res[b.cnt[RIDX_W-1:0]] = '{ev: ev, ch: ch, sty: sty};
			r.cnt = b.cnt + CNT_W'(1);
		end
		return r;
	endfunction

	assign items.ready = !q_full;
	assign accept      = items.valid && items.ready;

	always_comb begin
		phase_d      = phase_q;
		hdr_pos_d    = hdr_pos_q;
		first_line_d = first_line_q;
		line_zero_d  = line_zero_q;
		centred_d    = centred_q;
		pend_cnt_d   = pend_cnt_q;
		style_d      = style_q;
		pend_d[0]    = pend_q[0];
		pend_d[1]    = pend_q[1];
		bnd          = '0;
		rs_char      = 1'b0;
		rs_endl      = 1'b0;
		win[0]       = pend_q[0];
		win[1]       = pend_q[1];
		win[2]       = '0;
		rs_n         = pend_cnt_q;
		c            = '0;
		used         = 2'd0;

		case (items.kind)
			KIND_EOF: begin
				if (phase_q == PH_HEADER) begin
					bnd = put_res(bnd, EV_ERROR, '0, '0);
				end else if (phase_q == PH_BODY && !line_zero_q) begin
					rs_endl = 1'b1;
				end
			end
			KIND_EOL: begin
				case (phase_q)
					PH_HEADER: begin
						bnd     = put_res(bnd, EV_ERROR, '0, '0);
						phase_d = PH_ERROR;
					end
					PH_SKIP: phase_d = PH_BODY;
					PH_BODY: begin
						if (line_zero_q) begin
							if (!first_line_q) bnd = put_res(bnd, EV_PARA, '0, '0);
							first_line_d = 1'b0;
						end
						rs_endl = 1'b1;
					end
					default: ;
				endcase
			end
			KIND_CHAR: begin
				case (phase_q)
					PH_HEADER: begin
						if (items.code != hdr_unit(hdr_pos_q)) begin
							bnd     = put_res(bnd, EV_ERROR, '0, '0);
							phase_d = PH_ERROR;
						end else begin
							hdr_pos_d = hdr_pos_q + 4'd1;
							if (hdr_pos_q == 4'(HDR_LEN - 1)) phase_d = PH_SKIP;
						end
					end
					PH_BODY: begin
						if (line_zero_q) begin
							if (!first_line_q) bnd = put_res(bnd, EV_PARA, '0, '0);
							first_line_d = 1'b0;
							line_zero_d  = 1'b0;
						end
						if (line_zero_q && items.code == CH_GT) begin
							bnd       = put_res(bnd, EV_CENTRE, '0, '0);
							centred_d = 1'b1;
						end else begin
							rs_char          = 1'b1;
							win[pend_cnt_q]  = items.code;
							rs_n             = pend_cnt_q + 2'd1;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase

		// window resolution: at most three units, at least one unit per step
		rs_eol  = rs_endl;
		rs_stop = !(rs_char || rs_endl);
		for (int k = 0; k < 3; k++) begin
			if (!rs_stop && rs_n != 2'd0) begin
				c    = win[0];
				used = 2'd0;
				if (c == CH_BSLASH) begin
					if (rs_n >= 2'd2) begin
						bnd  = put_res(bnd, EV_CHAR, win[1], style_d);
						used = 2'd2;
					end else if (rs_eol) begin
						bnd  = put_res(bnd, EV_CHAR, c, style_d);
						used = 2'd1;
					end
				end else if (c == CH_LT && centred_q) begin
					if (rs_n >= 2'd2) begin
						bnd  = put_res(bnd, EV_CHAR, c, style_d);
						used = 2'd1;
					end else if (rs_eol) begin
						used = 2'd1;
					end
				end else if (c == CH_STAR) begin
					if (rs_n == 2'd3 && win[1] == CH_STAR && win[2] == CH_STAR) begin
						style_d[ST_BOLD]   = ~style_d[ST_BOLD];
						style_d[ST_ITALIC] = ~style_d[ST_ITALIC];
						used = 2'd3;
					end else if (rs_n >= 2'd2 && win[1] == CH_STAR
						&& (rs_n == 2'd3 || rs_eol)) begin
						style_d[ST_BOLD] = ~style_d[ST_BOLD];
						used = 2'd2;
					end else if ((rs_n >= 2'd2 && win[1] != CH_STAR)
						|| (rs_n == 2'd1 && rs_eol)) begin
						style_d[ST_ITALIC] = ~style_d[ST_ITALIC];
						used = 2'd1;
					end
				end else if (c == CH_UNDER) begin
					style_d[ST_UNDER] = ~style_d[ST_UNDER];
					used = 2'd1;
				end else if (c == CH_TILDE) begin
					if (rs_n >= 2'd2) begin
						if (win[1] == CH_TILDE) begin
							style_d[ST_STRIKE] = ~style_d[ST_STRIKE];
							used = 2'd2;
						end else begin
							bnd  = put_res(bnd, EV_CHAR, c, style_d);
							used = 2'd1;
						end
					end else if (rs_eol) begin
						bnd  = put_res(bnd, EV_CHAR, c, style_d);
						used = 2'd1;
					end
				end else begin
					bnd  = put_res(bnd, EV_CHAR, c, style_d);
					used = 2'd1;
				end

				if (used == 2'd0) begin
					rs_stop = 1'b1;
				end else begin
					case (used)
						2'd1: begin
							win[0] = win[1];
							win[1] = win[2];
						end
						2'd2: win[0] = win[2];
						default: ;
					endcase
					rs_n = rs_n - used;
				end
			end
		end

		if (rs_char) begin
			pend_d[0]  = win[0];
			pend_d[1]  = win[1];
			pend_cnt_d = (rs_n == 2'd3) ? 2'd2 : rs_n;
		end
		if (rs_endl) begin
			pend_cnt_d  = 2'd0;
			style_d     = '0;
			centred_d   = 1'b0;
			line_zero_d = 1'b1;
		end
		// end of file: back to the reset state for a new document
		if (items.kind == KIND_EOF) begin
			phase_d      = PH_HEADER;
			hdr_pos_d    = '0;
			first_line_d = 1'b1;
			line_zero_d  = 1'b1;
			centred_d    = 1'b0;
			pend_cnt_d   = 2'd0;
			style_d      = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HEADER;
			hdr_pos_q    <= '0;
			first_line_q <= 1'b1;
			line_zero_q  <= 1'b1;
			centred_q    <= 1'b0;
			pend_cnt_q   <= 2'd0;
			style_q      <= '0;
		end else if (accept) begin
			phase_q      <= phase_d;
			hdr_pos_q    <= hdr_pos_d;
			first_line_q <= first_line_d;
			line_zero_q  <= line_zero_d;
			centred_q    <= centred_d;
			pend_cnt_q   <= pend_cnt_d;
			style_q      <= style_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_q[0] <= pend_d[0];
			pend_q[1] <= pend_d[1];
		end
	end

	assign q_wr.push = accept && (bnd.cnt != '0);
	assign q_wr.data = bnd;

endmodule
`default_nettype wire

// ----- src/imsp_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imsp_queue: result bundle queue
// Short FIFO of per-request bundles between classification and output.
// ----------------------------------------------------------------------------
module imsp_queue #(
	parameter int unsigned Depth = imsp_pkg::QUEUE_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire imsp_pkg::q_wr_t wr,
	input  wire logic           pop,
	output logic                full,
	output imsp_pkg::q_rd_t     rd
);
	import imsp_pkg::*;

	localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	bundle_t         mem_q [Depth];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push, do_pop;

	assign full     = (cnt_q == CW'(Depth));
	assign rd.empty = (cnt_q == '0);
	assign rd.data  = mem_q[rd_ptr_q];
	assign do_push  = wr.push && !full;
	assign do_pop   = pop && !rd.empty;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wr.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(Depth - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(Depth - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ----- src/imsp_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imsp_back: result serializer
// Walks the head bundle one result per ready cycle and marks the final one.
// ----------------------------------------------------------------------------
module imsp_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire imsp_pkg::q_rd_t rd,
	output logic                pop,
	imsp_res_if.source          results
);
	import imsp_pkg::*;

	logic [RIDX_W-1:0] idx_q;
	res_t              cur;
	logic              is_last;
	logic              fire;

	assign cur     = rd.data.res[idx_q];
	assign is_last = (CNT_W'(idx_q) == rd.data.cnt - CNT_W'(1));
	assign fire    = results.valid && results.ready;
	assign pop     = fire && is_last;

	assign results.valid     = !rd.empty;
	assign results.event_res = cur.ev;
	assign results.char_out  = cur.ch;
	assign results.bold      = cur.sty[ST_BOLD];
	assign results.italic    = cur.sty[ST_ITALIC];
	assign results.underline = cur.sty[ST_UNDER];
	assign results.strike    = cur.sty[ST_STRIKE];
	assign results.last      = is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (fire) begin
			idx_q <= is_last ? '0 : idx_q + RIDX_W'(1);
		end
	end

endmodule
`default_nettype wire

// ----- src/inline_markup_style_parser_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// inline_markup_style_parser_core: inline markup style parser, top level
// Checks the document header, then turns code units into styled character,
// paragraph and centre events.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake      payload
//  --------  ---  -------------  --------------------------------------------
//  items     in   valid/ready    code[15:0], kind[1:0]
//  results   out  valid/ready    event_res[1:0], char_out[15:0], bold, italic,
//                                underline, strike, last
//
//  One request is taken per clock while the bundle queue has room; the front
//  resolves the two-unit lookahead window plus the new unit in that cycle.
//  Each result is one transfer on the results channel; a request causes zero
//  to four results, which pass through the queue and leave in request order.
//  One result per clock while results.ready is high bounds sustained throughput.
//  arst_n clears parse state, queue pointers and the serializer index; the
//  lookahead characters and queue entries are not reset.
//  A stalled results channel fills the queue (QDepth bundles), then items.ready
//  drops until a bundle has been fully delivered.
//
module inline_markup_style_parser_core #(
	parameter int unsigned QDepth = imsp_pkg::QUEUE_DEPTH
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	imsp_item_if.sink   items,
	imsp_res_if.source  results
);
	import imsp_pkg::*;

	q_wr_t q_wr;
	q_rd_t q_rd;
	logic  q_full;
	logic  q_pop;

	// front: header check, style toggles, lookahead, bundling of results
	imsp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items),
		.q_full (q_full),
		.q_wr   (q_wr)
	);

	// decouples request intake from result delivery
	imsp_queue #(
		.Depth (QDepth)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.pop    (q_pop),
		.full   (q_full),
		.rd     (q_rd)
	);

	// back: one result per handshake, last flag on the bundle's final entry
	imsp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd      (q_rd),
		.pop     (q_pop),
		.results (results)
	);

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for inline_markup_style_parser_core
// Sends whole documents (header line, markup-heavy body lines, end of file,
// plus broken headers and noise) through the item channel with random gaps
// and random result back-pressure. A cycle-free model of the parser computes
// the styled character, paragraph, centre and header-error events that each
// request should cause, and every result is matched against the oldest one.
// ----------------------------------------------------------------------------
module tb;
	import imsp_pkg::*;

	// kind code the parser must ignore
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	// document header, one byte per unit, first unit in the top byte
	localparam logic [71:0] MAGIC = "/*MTXT1*/";

	localparam logic [CHAR_W-1:0] CH_LOWER_A = 16'h0061;
	localparam logic [CHAR_W-1:0] CH_SLASH   = 16'h002F;

	// drain: cycles allowed for stray results after the last expected one
	localparam int DRAIN_CYCLES = 20;

	typedef enum logic [1:0] {
		DOC_HEADER,
		DOC_SKIP,
		DOC_BODY,
		DOC_BROKEN
	} doc_phase_t;

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic [KIND_W-1:0] kind;
	} unit_req_t;

	typedef struct packed {
		logic [EV_W-1:0]   ev;
		logic [CHAR_W-1:0] ch;
		logic [STY_W-1:0]  sty;
		logic              last;
	} styled_ev_t;

	logic clk = 1'b0;
	logic arst_n;

	imsp_item_if items_ch ();
	imsp_res_if  res_ch ();

	inline_markup_style_parser_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_ch),
		.results (res_ch)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// Stimulus and scoreboard storage
	// ------------------------------------------------------------------------
	unit_req_t  pending_units[$];    // requests not yet offered to the parser
	styled_ev_t expected_events[$];  // events the parser still owes us
	styled_ev_t step_events[$];      // events of the request being predicted

	int  mismatch_count = 0;
	int  stim_count     = 0;         // requests that reach header or body logic
	int  src_idle_pct   = 0;
	int  snk_idle_pct   = 0;
	bit  item_taken     = 1'b0;

	// ------------------------------------------------------------------------
	// Parser model state
	// ------------------------------------------------------------------------
	doc_phase_t        doc_phase;
	logic [3:0]        hdr_pos;
	bit                first_line;   // first body line opens no paragraph event
	bit                line_start;   // no unit seen yet on the current line
	bit                centred;      // line opened with '>'
	logic [CHAR_W-1:0] pend [0:1];   // lookahead units held back
	int                pend_n;
	logic [STY_W-1:0]  sty;

	// working window: lookahead plus the new unit
	logic [CHAR_W-1:0] win [0:2];
	int                win_n;

	function logic [CHAR_W-1:0] magic_unit(input int p);
		return {8'h00, MAGIC[(8 - p) * 8 +: 8]};
	endfunction

	function void clear_doc_state();
		doc_phase  = DOC_HEADER;
		hdr_pos    = '0;
		first_line = 1'b1;
		line_start = 1'b1;
		centred    = 1'b0;
		pend[0]    = '0;
		pend[1]    = '0;
		pend_n     = 0;
		sty        = '0;
	endfunction

	// at most MAX_RES events per request; extras are dropped
	function void add_event(input logic [EV_W-1:0] ev, input logic [CHAR_W-1:0] ch,
		input logic [STY_W-1:0] s);
		styled_ev_t r;
		if (step_events.size() < MAX_RES) begin
			r.ev   = ev;
			r.ch   = ch;
			r.sty  = s;
			r.last = 1'b0;
			step_events.push_back(r);
		end
	endfunction

	function void open_paragraph();
		if (!first_line)
			add_event(EV_PARA, '0, '0);
		first_line = 1'b0;
	endfunction

	// Consume what can be decided at the head of the window. With eol set
	// the line ends after the window, so nothing more can follow.
	function void drain_window(input bit eol);
		logic [CHAR_W-1:0] c;
		int used;
		bit stuck;
		stuck = 1'b0;
		while (win_n > 0 && !stuck) begin
			c    = win[0];
			used = 0;
			if (c == CH_BSLASH) begin
				if (win_n >= 2) begin
					add_event(EV_CHAR, win[1], sty);
					used = 2;
				end else if (eol) begin
					// backslash at line end is literal
					add_event(EV_CHAR, c, sty);
					used = 1;
				end
			end else if (c == CH_LT && centred) begin
				if (win_n >= 2) begin
					add_event(EV_CHAR, c, sty);
					used = 1;
				end else if (eol) begin
					used = 1;
				end
			end else if (c == CH_STAR) begin
				if (win_n >= 3 && win[1] == CH_STAR && win[2] == CH_STAR) begin
					sty[ST_BOLD]   = ~sty[ST_BOLD];
					sty[ST_ITALIC] = ~sty[ST_ITALIC];
					used = 3;
				end else if (win_n >= 2 && win[1] == CH_STAR && (win_n >= 3 || eol)) begin
					sty[ST_BOLD] = ~sty[ST_BOLD];
					used = 2;
				end else if ((win_n >= 2 && win[1] != CH_STAR) || (win_n == 1 && eol)) begin
					sty[ST_ITALIC] = ~sty[ST_ITALIC];
					used = 1;
				end
			end else if (c == CH_UNDER) begin
				sty[ST_UNDER] = ~sty[ST_UNDER];
				used = 1;
			end else if (c == CH_TILDE) begin
				if (win_n >= 2) begin
					if (win[1] == CH_TILDE) begin
						sty[ST_STRIKE] = ~sty[ST_STRIKE];
						used = 2;
					end else begin
						add_event(EV_CHAR, c, sty);
						used = 1;
					end
				end else if (eol) begin
					add_event(EV_CHAR, c, sty);
					used = 1;
				end
			end else begin
				add_event(EV_CHAR, c, sty);
				used = 1;
			end
			if (used == 0) begin
				stuck = 1'b1;
			end else begin
				for (int i = 0; i < 3; i++)
					win[i] = (i + used < 3) ? win[i + used] : '0;
				win_n -= used;
			end
		end
	endfunction

	function void close_line();
		if (line_start)
			open_paragraph();
		win[0] = pend[0];
		win[1] = pend[1];
		win[2] = '0;
		win_n  = pend_n;
		drain_window(1'b1);
		pend_n     = 0;
		sty        = '0;
		centred    = 1'b0;
		line_start = 1'b1;
	endfunction

	// Predict the events of one accepted request and queue them.
	function void parse_unit(input logic [CHAR_W-1:0] code, input logic [KIND_W-1:0] kind);
		int p;
		bit handled;
		styled_ev_t r;
		step_events.delete();
		case (kind)
			KIND_EOF: begin
				if (doc_phase == DOC_HEADER)
					add_event(EV_ERROR, '0, '0);
				else if (doc_phase == DOC_BODY && !line_start)
					close_line();
				clear_doc_state();
			end
			KIND_EOL: begin
				case (doc_phase)
					DOC_HEADER: begin
						add_event(EV_ERROR, '0, '0);
						doc_phase = DOC_BROKEN;
					end
					DOC_SKIP: doc_phase = DOC_BODY;
					DOC_BODY: close_line();
					default: ;
				endcase
			end
			KIND_CHAR: begin
				if (doc_phase == DOC_HEADER) begin
					p = (hdr_pos < 9) ? int'(hdr_pos) : 8;
					if (code != magic_unit(p)) begin
						add_event(EV_ERROR, '0, '0);
						doc_phase = DOC_BROKEN;
					end else begin
						hdr_pos = 4'(p + 1);
						if (hdr_pos >= 9)
							doc_phase = DOC_SKIP;
					end
				end else if (doc_phase == DOC_BODY) begin
					handled = 1'b0;
					if (line_start) begin
						open_paragraph();
						line_start = 1'b0;
						if (code == CH_GT) begin
							add_event(EV_CENTRE, '0, '0);
							centred = 1'b1;
							handled = 1'b1;
						end
					end
					if (!handled) begin
						win[0] = pend[0];
						win[1] = pend[1];
						win[2] = '0;
						win_n  = pend_n;
						win[win_n] = code;
						win_n++;
						drain_window(1'b0);
						pend[0] = (win_n > 0) ? win[0] : '0;
						pend[1] = (win_n > 1) ? win[1] : '0;
						pend_n  = win_n;
					end
				end
			end
			default: ;
		endcase
		if (step_events.size() > 0) begin
			r = step_events.pop_back();
			r.last = 1'b1;
			step_events.push_back(r);
		end
		foreach (step_events[i])
			expected_events.push_back(step_events[i]);
	endfunction

	task report_mismatch(input string what, input logic [CHAR_W-1:0] got,
		input logic [CHAR_W-1:0] want);
		$display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
		mismatch_count++;
	endtask

	// ------------------------------------------------------------------------
	// Driver: requests change on the falling edge. A request stays up until it
	// is taken; the next one is raised in the same assignment, never dropped
	// and raised again within one step.
	// ------------------------------------------------------------------------
	always @(negedge clk) begin : drive
		unit_req_t nxt;
		if (arst_n) begin
			if (!items_ch.valid || item_taken) begin
				if (pending_units.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
					nxt = pending_units.pop_front();
					items_ch.valid <= 1'b1;
					items_ch.code  <= nxt.code;
					items_ch.kind  <= nxt.kind;
				end else begin
					items_ch.valid <= 1'b0;
				end
			end
			res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: both handshakes sampled on the rising edge. The request is
	// predicted before the result is checked, in case one lands on the same
	// edge.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : watch
		styled_ev_t want;
		item_taken <= arst_n && items_ch.valid && items_ch.ready;
		if (arst_n) begin
			if (items_ch.valid && items_ch.ready)
				parse_unit(items_ch.code, items_ch.kind);
			if (res_ch.valid && res_ch.ready) begin
				if (expected_events.size() == 0) begin
					report_mismatch("unexpected result event",
						CHAR_W'(res_ch.event_res), '0);
				end else begin
					want = expected_events.pop_front();
					if (res_ch.event_res !== want.ev)
						report_mismatch("event_res", CHAR_W'(res_ch.event_res),
							CHAR_W'(want.ev));
					if (res_ch.char_out !== want.ch)
						report_mismatch("char_out", res_ch.char_out, want.ch);
					if (res_ch.bold !== want.sty[ST_BOLD])
						report_mismatch("bold", CHAR_W'(res_ch.bold),
							CHAR_W'(want.sty[ST_BOLD]));
					if (res_ch.italic !== want.sty[ST_ITALIC])
						report_mismatch("italic", CHAR_W'(res_ch.italic),
							CHAR_W'(want.sty[ST_ITALIC]));
					if (res_ch.underline !== want.sty[ST_UNDER])
						report_mismatch("underline", CHAR_W'(res_ch.underline),
							CHAR_W'(want.sty[ST_UNDER]));
					if (res_ch.strike !== want.sty[ST_STRIKE])
						report_mismatch("strike", CHAR_W'(res_ch.strike),
							CHAR_W'(want.sty[ST_STRIKE]));
					if (res_ch.last !== want.last)
						report_mismatch("last", CHAR_W'(res_ch.last), CHAR_W'(want.last));
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus generation
	// ------------------------------------------------------------------------
	task push_unit(input logic [CHAR_W-1:0] code, input logic [KIND_W-1:0] kind,
		input bit counted);
		unit_req_t u;
		u.code = code;
		u.kind = kind;
		pending_units.push_back(u);
		if (counted)
			stim_count++;
	endtask

	task push_magic();
		for (int i = 0; i < HDR_LEN; i++)
			push_unit(magic_unit(i), KIND_CHAR, 1'b1);
	endtask

	// body units are weighted toward markup so style toggles stack up
	function logic [CHAR_W-1:0] body_unit();
		case ($urandom_range(15))
			0, 1, 2: return CH_STAR;
			3:       return CH_UNDER;
			4, 5:    return CH_TILDE;
			6:       return CH_BSLASH;
			7:       return CH_LT;
			8:       return CH_GT;
			9:       return CHAR_W'($urandom);
			10:      return CH_SLASH;
			default: return CH_LOWER_A + CHAR_W'($urandom_range(25));
		endcase
	endfunction

	// items swallowed after a header error; end of file is left to the caller
	task push_noise();
		int n;
		n = $urandom_range(4);
		repeat (n) begin
			case ($urandom_range(2))
				0: push_unit(CHAR_W'($urandom), KIND_CHAR, 1'b0);
				1: push_unit(CHAR_W'($urandom), KIND_EOL, 1'b0);
				default: push_unit(CHAR_W'($urandom), KIND_UNUSED, 1'b0);
			endcase
		end
	endtask

	task gen_document();
		int p;
		int lines;
		int len;
		logic [CHAR_W-1:0] bad;
		if ($urandom_range(99) < 12) begin
			// broken header: a matching prefix, then a wrong unit or an early end
			p = $urandom_range(HDR_LEN - 1);
			for (int i = 0; i < p; i++)
				push_unit(magic_unit(i), KIND_CHAR, 1'b1);
			case ($urandom_range(2))
				0: begin
					bad = CHAR_W'($urandom);
					if (bad == magic_unit(p))
						bad = bad ^ 16'h0001;
					push_unit(bad, KIND_CHAR, 1'b1);
					push_noise();
					push_unit(CHAR_W'($urandom), KIND_EOF, 1'b1);
				end
				1: begin
					push_unit(CHAR_W'($urandom), KIND_EOL, 1'b1);
					push_noise();
					push_unit(CHAR_W'($urandom), KIND_EOF, 1'b1);
				end
				default: push_unit(CHAR_W'($urandom), KIND_EOF, 1'b1);
			endcase
		end else begin
			push_magic();
			// rest of the header line is skipped
			if ($urandom_range(4) == 0)
				repeat ($urandom_range(1, 3)) push_unit(CHAR_W'($urandom), KIND_CHAR, 1'b0);
			push_unit(CHAR_W'($urandom), KIND_EOL, 1'b1);
			lines = $urandom_range(1, 6);
			for (int l = 0; l < lines; l++) begin
				len = $urandom_range(9);
				for (int k = 0; k < len; k++) begin
					if (k == 0 && $urandom_range(3) == 0)
						push_unit(CH_GT, KIND_CHAR, 1'b1);
					else if (k == len - 1 && $urandom_range(3) == 0)
						push_unit(CH_LT, KIND_CHAR, 1'b1);
					else
						push_unit(body_unit(), KIND_CHAR, 1'b1);
					if ($urandom_range(99) < 3)
						push_unit(CHAR_W'($urandom), KIND_UNUSED, 1'b0);
				end
				// last line is sometimes left open for end of file to close
				if (l < lines - 1 || $urandom_range(3) != 0)
					push_unit(CHAR_W'($urandom), KIND_EOL, 1'b1);
			end
			push_unit(CHAR_W'($urandom), KIND_EOF, 1'b1);
		end
	endtask

	// sender holds off until the parser owes nothing
	task wait_quiet();
		@(negedge clk);
		while (pending_units.size() > 0 || items_ch.valid || expected_events.size() > 0)
			@(negedge clk);
	endtask

	task run_random(input int n_req, input int src_pct, input int snk_pct);
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		stim_count   = 0;
		while (stim_count < n_req)
			gen_document();
		wait_quiet();
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		clear_doc_state();
		arst_n          = 1'b0;
		items_ch.valid  = 1'b0;
		items_ch.code   = '0;
		items_ch.kind   = KIND_CHAR;
		res_ch.ready    = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed document: skipped header tail, centred line with all
		// markers, extreme code units, lone tilde, dropped closing '<',
		// empty line, backslash closed by end of file.
		src_idle_pct = 22;
		snk_idle_pct = 84;
		push_magic();
		push_unit(CH_LOWER_A, KIND_CHAR, 1'b1);
		push_unit('0, KIND_EOL, 1'b1);
		push_unit(CH_GT, KIND_CHAR, 1'b1);
		push_unit(CH_STAR, KIND_CHAR, 1'b1);
		push_unit(CH_STAR, KIND_CHAR, 1'b1);
		push_unit(CH_STAR, KIND_CHAR, 1'b1);
		push_unit(16'hFFFF, KIND_CHAR, 1'b1);
		push_unit(CH_BSLASH, KIND_CHAR, 1'b1);
		push_unit(CH_UNDER, KIND_CHAR, 1'b1);
		push_unit(CH_TILDE, KIND_CHAR, 1'b1);
		push_unit(CH_STAR, KIND_CHAR, 1'b1);
		push_unit(CH_STAR, KIND_CHAR, 1'b1);
		push_unit(16'h0000, KIND_CHAR, 1'b1);
		push_unit(CH_TILDE, KIND_CHAR, 1'b1);
		push_unit(CH_TILDE, KIND_CHAR, 1'b1);
		push_unit(CH_LT, KIND_CHAR, 1'b1);
		push_unit(16'hFFFF, KIND_EOL, 1'b1);
		push_unit('0, KIND_EOL, 1'b1);
		push_unit(CH_BSLASH, KIND_CHAR, 1'b1);
		push_unit(16'hFFFF, KIND_UNUSED, 1'b1);
		push_unit('0, KIND_EOF, 1'b1);
		// header cut short by a line end
		push_unit(CH_SLASH, KIND_CHAR, 1'b1);
		push_unit('0, KIND_EOL, 1'b1);
		push_unit('0, KIND_EOF, 1'b1);
		wait_quiet();

		// random documents under three gap patterns
		run_random(80, 22, 84);
		run_random(80, 84, 22);
		run_random(80, 0, 0);

		// let any stray result show up
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_events.size() != 0)
			report_mismatch("events never delivered", 16'(expected_events.size()), '0);

		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#3_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
